/* rtl/core/sig_pkg.sv */
// Shared types and constants for the sortable id generator.
// No dependencies; used by every module under rtl/core.
package sig_pkg;

  localparam int TIME_W    = 50;
  localparam int TAG_W     = 15;
  localparam int SEQ_W     = 64;
  localparam int CODE_W    = 5;
  localparam int CHAR_W    = 7;
  localparam int POS_W     = 5;
  localparam int NUM_CHARS = 26;
  localparam int WORD_W    = NUM_CHARS * CODE_W;  // time : tag : zero bit : sequence
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_CHARS - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_TAG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_CLOCK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FROZEN_MS    = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]  process_tag;
    logic              freeze_clock;
    logic [TIME_W-1:0] frozen_ms;
  } cfg_t;

  // Crockford base32 digit to ASCII (no I, L, O, U)
  function automatic logic [CHAR_W-1:0] b32_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      5'd0:  c = 7'd48;  // '0'
      5'd1:  c = 7'd49;
      5'd2:  c = 7'd50;
      5'd3:  c = 7'd51;
      5'd4:  c = 7'd52;
      5'd5:  c = 7'd53;
      5'd6:  c = 7'd54;
      5'd7:  c = 7'd55;
      5'd8:  c = 7'd56;
      5'd9:  c = 7'd57;  // '9'
      5'd10: c = 7'd65;  // 'A'
      5'd11: c = 7'd66;
      5'd12: c = 7'd67;
      5'd13: c = 7'd68;
      5'd14: c = 7'd69;
      5'd15: c = 7'd70;
      5'd16: c = 7'd71;
      5'd17: c = 7'd72;  // 'H'
      5'd18: c = 7'd74;  // 'J'
      5'd19: c = 7'd75;  // 'K'
      5'd20: c = 7'd77;  // 'M'
      5'd21: c = 7'd78;  // 'N'
      5'd22: c = 7'd80;  // 'P'
      5'd23: c = 7'd81;
      5'd24: c = 7'd82;
      5'd25: c = 7'd83;
      5'd26: c = 7'd84;  // 'T'
      5'd27: c = 7'd86;  // 'V'
      5'd28: c = 7'd87;
      5'd29: c = 7'd88;
      5'd30: c = 7'd89;
      5'd31: c = 7'd90;  // 'Z'
      default: c = 7'd48;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/sig_stamp.sv */
// Time selection, monotonic sequence counter and id word holding register.
// Depends on sig_pkg.
module sig_stamp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [sig_pkg::TIME_W-1:0]  now_ms,
  input  sig_pkg::cfg_t               cfg,
  input  logic                        take,
  output logic                        word_vld,
  output logic [sig_pkg::WORD_W-1:0]  word
);

  logic [sig_pkg::TIME_W-1:0] last_time_r, last_time_nxt;
  logic [sig_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic [sig_pkg::WORD_W-1:0] word_r, word_nxt;
  logic                       vld_r, vld_nxt;

  logic [sig_pkg::TIME_W-1:0] ms;
  logic [sig_pkg::TAG_W-1:0]  tag;
  logic [sig_pkg::SEQ_W-1:0]  seq_inc;

  always_comb begin
    ms      = cfg.freeze_clock ? cfg.frozen_ms : now_ms;
    tag     = cfg.freeze_clock ? '0 : cfg.process_tag;
    // new millisecond restarts the count; wraps silently at 2^64
    seq_inc = ((ms != last_time_r) ? '0 : seq_r) + sig_pkg::SEQ_W'(1);

    last_time_nxt = last_time_r;
    seq_nxt       = seq_r;
    word_nxt      = word_r;
    vld_nxt       = vld_r & ~take;
    if (accept) begin
      last_time_nxt = ms;
      seq_nxt       = seq_inc;
      word_nxt      = {ms, tag, 1'b0, seq_inc};
      vld_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      seq_r       <= '0;
      vld_r       <= 1'b0;
    end else begin
      last_time_r <= last_time_nxt;
      seq_r       <= seq_nxt;
      vld_r       <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_vld = vld_r;
  assign word     = word_r;

endmodule

/* rtl/core/sig_serial.sv */
// Character serializer: shifts the 130-bit id word out as 26 base32 characters.
// Depends on sig_pkg.
module sig_serial (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        word_vld,
  input  logic [sig_pkg::WORD_W-1:0]  word,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sig_pkg::CHAR_W-1:0]  out_id_char,
  output logic [sig_pkg::POS_W-1:0]   out_char_pos,
  output logic                        out_last
);

  logic                       busy_r, busy_nxt;
  logic [sig_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [sig_pkg::WORD_W-1:0] shift_r, shift_nxt;
  logic                       at_last;
  logic                       finish;

  always_comb begin
    at_last = (pos_r == sig_pkg::LAST_POS);
    finish  = busy_r && out_ready && at_last;
    take    = word_vld && (!busy_r || finish);

    busy_nxt  = busy_r;
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    if (take) begin
      busy_nxt  = 1'b1;
      pos_nxt   = '0;
      shift_nxt = word;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_ready) begin
      pos_nxt   = pos_r + sig_pkg::POS_W'(1);
      shift_nxt = {shift_r[sig_pkg::WORD_W-sig_pkg::CODE_W-1:0], sig_pkg::CODE_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign out_valid    = busy_r;
  assign out_id_char  =
    sig_pkg::b32_char(shift_r[sig_pkg::WORD_W-1 -: sig_pkg::CODE_W]);
  assign out_char_pos = pos_r;
  assign out_last     = at_last;

endmodule

/* rtl/core/sortable_id_generator_unit.sv */
// Sortable id generator: ULID-style 26-character base32 ids, monotonic per ms.
// Path: an accepted request is built into the stamp holding word, then loaded into the serializer shift register.
// Throughput: one character per cycle while out_ready is high, set by the serializer.
// A second request is held in a one-word buffer while the previous id drains.
// Reset (synchronous, rst_n low): config, last time and sequence count clear to 0.
// Depends on sig_pkg, sig_stamp, sig_serial.
module sortable_id_generator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [sig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sig_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sig_pkg::TIME_W-1:0]     in_now_ms,
  // character channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sig_pkg::CHAR_W-1:0]     out_id_char,
  output logic [sig_pkg::POS_W-1:0]      out_char_pos,
  output logic                           out_last
);

  sig_pkg::cfg_t cfg_r, cfg_nxt;

  logic                       accept;
  logic                       take;
  logic                       word_vld;
  logic [sig_pkg::WORD_W-1:0] word;

  // Config registers; index 3 is unmapped and the write is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sig_pkg::CFG_PROCESS_TAG:  cfg_nxt.process_tag  = cfg_wdata[sig_pkg::TAG_W-1:0];
        sig_pkg::CFG_FREEZE_CLOCK: cfg_nxt.freeze_clock = cfg_wdata[0];
        sig_pkg::CFG_FROZEN_MS:    cfg_nxt.frozen_ms    = cfg_wdata[sig_pkg::TIME_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Holding word is free, or is handed to the serializer this cycle.
  assign in_ready = !word_vld || take;
  assign accept   = in_valid && in_ready;

  // Time pick, sequence update and id word build happen on the accepting edge.
  sig_stamp u_stamp (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .now_ms   (in_now_ms),
    .cfg      (cfg_r),
    .take     (take),
    .word_vld (word_vld),
    .word     (word)
  );

  // Emits characters most significant first; reloads straight after the last one.
  sig_serial u_serial (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_vld     (word_vld),
    .word         (word),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_id_char  (out_id_char),
    .out_char_pos (out_char_pos),
    .out_last     (out_last)
  );

endmodule
